// ----- src/rthc_pkg.sv -----
// Shared types, constants and tables for the RGB to HSI converter.
package rthc_pkg;

	localparam int FRAC_BITS  = 12;
	localparam int FIELD_W    = 13;
	localparam int SUM_W      = 15;
	localparam int ANG_BITS   = 20;
	localparam int STEPS      = 19;
	localparam int STEP_W     = 5;
	localparam int XY_W       = 36;
	localparam int QUO_BITS   = 13;
	localparam int DEN_W      = 16;
	localparam int REM_W      = 29;
	localparam int SQRT3_Q16  = 113512;
	localparam int THIRD_MUL  = 43691;

	typedef enum logic [1:0] {
		HUE_CORDIC,
		HUE_ZERO,
		HUE_HALF
	} hue_sel_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic [ANG_BITS-1:0]    acc;
		logic [REM_W-1:0]       rem;
		logic [DEN_W-1:0]       den;
		logic [QUO_BITS-1:0]    quo;
		hue_sel_t               hue_sel;
		logic                   sat_full;
		logic [FIELD_W-1:0]     inten;
	} cell_data_t;

	localparam logic [ANG_BITS-1:0] ATAN_TAB [STEPS] = '{
		20'd131072, 20'd77376, 20'd40884, 20'd20753, 20'd10417, 20'd5213, 20'd2607,
		20'd1304, 20'd652, 20'd326, 20'd163, 20'd81, 20'd41, 20'd20, 20'd10, 20'd5,
		20'd3, 20'd1, 20'd1
	};

endpackage

// ----- src/rthc_front.sv -----
// Front stages: sums, minimum, intensity, CORDIC start vector and division setup.
module rthc_front import rthc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               src_valid,
	input  logic [FIELD_W-1:0] red,
	input  logic [FIELD_W-1:0] green,
	input  logic [FIELD_W-1:0] blue,
	output logic               dst_valid,
	output cell_data_t         dst_data
);

	logic [SUM_W-1:0]         sum;
	logic [FIELD_W-1:0]       mn;
	logic signed [SUM_W:0]    x0;
	logic signed [FIELD_W:0]  dgb;
	hue_sel_t                 hue_sel;

	logic                     valid_s1;
	logic [SUM_W-1:0]         sum_s1;
	logic [FIELD_W-1:0]       mn_s1;
	logic signed [SUM_W:0]    x0_s1;
	logic signed [FIELD_W:0]  dgb_s1;
	hue_sel_t                 hue_sel_s1;
	logic                     zero_s1;

	logic signed [31:0]       y_prod;
	logic [31:0]              third;
	logic signed [XY_W-1:0]   x_ext;
	logic signed [XY_W-1:0]   y_ext;
	logic [SUM_W-1:0]         diff;
	cell_data_t               next;

	always_comb begin
		sum = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
		mn = red;
		if (green < mn) begin
			mn = green;
		end
		if (blue < mn) begin
			mn = blue;
		end
		x0 = $signed({2'b00, red, 1'b0}) - $signed({3'b000, green}) - $signed({3'b000, blue});
		dgb = $signed({1'b0, green}) - $signed({1'b0, blue});
		if (sum == '0 || (red == green && green == blue)) begin
			hue_sel = HUE_ZERO;
		end else if (green == blue) begin
			hue_sel = (x0 > 0) ? HUE_ZERO : HUE_HALF;
		end else begin
			hue_sel = HUE_CORDIC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1     <= sum;
			mn_s1      <= mn;
			x0_s1      <= x0;
			dgb_s1     <= dgb;
			hue_sel_s1 <= hue_sel;
			zero_s1    <= (sum == '0);
		end
	end

	always_comb begin
		y_prod = 32'(dgb_s1) * SQRT3_Q16;
		third  = (32'(sum_s1) + 32'd1) * 32'(THIRD_MUL);
		x_ext  = XY_W'(x0_s1) <<< 16;
		y_ext  = XY_W'(y_prod);
		diff   = sum_s1 - 15'(3 * mn_s1);
		next.acc = '0;
		next.x   = x_ext;
		next.y   = y_ext;
		if (x0_s1 < 0) begin
			next.x   = -x_ext;
			next.y   = -y_ext;
			next.acc = ANG_BITS'(1) << (ANG_BITS - 1);
		end
		next.rem      = ({14'b0, diff} << QUO_BITS) + REM_W'(sum_s1);
		next.den      = {sum_s1, 1'b0};
		next.quo      = '0;
		next.hue_sel  = hue_sel_s1;
		next.sat_full = zero_s1;
		next.inten    = third[17 +: FIELD_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid <= 1'b0;
		end else if (en) begin
			dst_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dst_data <= next;
		end
	end

endmodule

// ----- src/rthc_cell.sv -----
// Chain cell: a CORDIC vectoring step and, for steps below 13, one saturation quotient bit.
module rthc_cell import rthc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [STEP_W-1:0] step,
	input  logic              src_valid,
	input  cell_data_t        src_data,
	output logic              dst_valid,
	output cell_data_t        dst_data
);

	logic signed [XY_W-1:0] dx;
	logic signed [XY_W-1:0] dy;
	logic [3:0]             k;
	logic [REM_W:0]         trial;
	cell_data_t             next;

	always_comb begin
		next = src_data;
		dx = src_data.y >>> step;
		dy = src_data.x >>> step;
		if (src_data.y > 0) begin
			next.x   = src_data.x + dx;
			next.y   = src_data.y - dy;
			next.acc = src_data.acc + ATAN_TAB[step];
		end else begin
			next.x   = src_data.x - dx;
			next.y   = src_data.y + dy;
			next.acc = src_data.acc - ATAN_TAB[step];
		end
		k = 4'(QUO_BITS - 1 - int'(step));
		trial = {1'b0, src_data.rem} - ((REM_W + 1)'(src_data.den) << k);
		if (int'(step) < QUO_BITS && !trial[REM_W]) begin
			next.rem    = trial[REM_W-1:0];
			next.quo[k] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid <= 1'b0;
		end else if (en) begin
			dst_valid <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dst_data <= next;
		end
	end

endmodule

// ----- src/rgb_to_hsi_convert_core.sv -----
// RGB to HSI converter top level: front stages, chain of CORDIC cells and output register.
// A pixel is taken every clock while no result waits under stall, and its result is presented
// through 22 register stages: two front stages, one cell per CORDIC step (19), the first
// 13 of which also carry the 13 bit saturation divide, and the output register. The whole
// pipeline holds while a result waits under stall.
module rgb_to_hsi_convert_core import rthc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_stall,
	input  logic [FIELD_W-1:0] red,
	input  logic [FIELD_W-1:0] green,
	input  logic [FIELD_W-1:0] blue,
	output logic               hsi_valid,
	input  logic               hsi_stall,
	output logic [FIELD_W-1:0] hue,
	output logic [FIELD_W-1:0] saturation,
	output logic [FIELD_W-1:0] intensity
);

	logic                 en;
	logic                 chain_valid [STEPS+1];
	cell_data_t           chain_data  [STEPS+1];
	cell_data_t           last;
	logic [32:0]          hue_full;
	logic [FIELD_W-1:0]   hue_next;

	assign en        = ~(hsi_valid & hsi_stall);
	assign pix_stall = ~en;

	rthc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (pix_valid),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.dst_valid (chain_valid[0]),
		.dst_data  (chain_data[0])
	);

	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		rthc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.step      (STEP_W'(i)),
			.src_valid (chain_valid[i]),
			.src_data  (chain_data[i]),
			.dst_valid (chain_valid[i+1]),
			.dst_data  (chain_data[i+1])
		);
	end

	always_comb begin
		last = chain_data[STEPS];
		hue_full = (33'(last.acc) << FRAC_BITS) + (33'(1) << (ANG_BITS - 1));
		case (last.hue_sel)
			HUE_CORDIC: hue_next = hue_full[ANG_BITS +: FIELD_W];
			HUE_HALF:   hue_next = FIELD_W'(1) << (FRAC_BITS - 1);
			default:    hue_next = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsi_valid <= 1'b0;
		end else if (en) begin
			hsi_valid <= chain_valid[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue        <= hue_next;
			saturation <= last.sat_full ? FIELD_W'(1) << FRAC_BITS : last.quo;
			intensity  <= last.inten;
		end
	end

endmodule

// ----- sim/tb.sv -----
// Testbench for the RGB to HSI converter: random and directed pixels checked against a model.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rthc_pkg::*;

	typedef struct {
		logic [FIELD_W-1:0] h;
		logic [FIELD_W-1:0] s;
		logic [FIELD_W-1:0] i;
	} hsi_t;

	function automatic longint floor_shift(longint v, int sh);
		if (v >= 0)
			return v >>> sh;
		return -(((-v) - 1) >>> sh) - 1;
	endfunction

	function automatic longint hue_angle(longint x, longint y);
		longint a;
		longint dx;
		longint dy;
		a = 0;
		if (x < 0) begin
			x = -x;
			y = -y;
			a = longint'(1) << (ANG_BITS - 1);
		end
		for (int k = 0; k < STEPS; k++) begin
			dx = floor_shift(y, k);
			dy = floor_shift(x, k);
			if (y > 0) begin
				x += dx;
				y -= dy;
				a += longint'(ATAN_TAB[k]);
			end else begin
				x -= dx;
				y += dy;
				a -= longint'(ATAN_TAB[k]);
			end
		end
		return a & ((longint'(1) << ANG_BITS) - 1);
	endfunction

	function automatic hsi_t convert_pixel(longint r, longint g, longint b);
		hsi_t o;
		longint sum;
		longint mn;
		longint hv;
		longint sv;
		longint x0;
		bit eq;
		sum = r + g + b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		eq = (r == g) && (g == b);
		hv = 0;
		if (sum == 0)
			sv = longint'(1) << FRAC_BITS;
		else if (eq)
			sv = 0;
		else
			sv = (((sum - 3 * mn) << (FRAC_BITS + 1)) + sum) / (sum * 2);
		if (sum != 0 && !eq) begin
			x0 = 2 * r - g - b;
			if (g == b)
				hv = (x0 > 0) ? 0 : (longint'(1) << (FRAC_BITS - 1));
			else
				hv = ((hue_angle(x0 * 65536, (g - b) * SQRT3_Q16) << FRAC_BITS)
					+ (longint'(1) << (ANG_BITS - 1))) >>> ANG_BITS;
		end
		o.h = hv[FIELD_W-1:0];
		o.s = sv[FIELD_W-1:0];
		o.i = FIELD_W'((sum + 1) / 3);
		return o;
	endfunction

	class hsi_scoreboard;
		hsi_t pending[$];
		int errors;

		function void note_pixel(logic [FIELD_W-1:0] r, logic [FIELD_W-1:0] g,
				logic [FIELD_W-1:0] b);
			pending = {pending, convert_pixel(r, g, b)};
		endfunction

		function void check_result(logic [FIELD_W-1:0] h, logic [FIELD_W-1:0] s,
				logic [FIELD_W-1:0] i);
			hsi_t e;
			if (pending.size() == 0) begin
				$error("unexpected result hue=%0d sat=%0d int=%0d", h, s, i);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (h !== e.h) begin
				$error("hue expected %0d actual %0d", e.h, h);
				errors++;
			end
			if (s !== e.s) begin
				$error("saturation expected %0d actual %0d", e.s, s);
				errors++;
			end
			if (i !== e.i) begin
				$error("intensity expected %0d actual %0d", e.i, i);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic pix_valid = 0;
	logic pix_stall;
	logic [FIELD_W-1:0] red = 0;
	logic [FIELD_W-1:0] green = 0;
	logic [FIELD_W-1:0] blue = 0;
	logic hsi_valid;
	logic hsi_stall = 0;
	logic [FIELD_W-1:0] hue;
	logic [FIELD_W-1:0] saturation;
	logic [FIELD_W-1:0] intensity;

	hsi_scoreboard board = new();
	bit calm;
	bit stimulus_done;

	rgb_to_hsi_convert_core dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(posedge clk) begin
		if (arst_n && pix_valid && !pix_stall)
			board.note_pixel(red, green, blue);
		if (arst_n && hsi_valid && !hsi_stall)
			board.check_result(hue, saturation, intensity);
	end

	task automatic send_pixel(logic [FIELD_W-1:0] r, logic [FIELD_W-1:0] g,
			logic [FIELD_W-1:0] b);
		while (!calm && $urandom_range(99) < 31) begin
			pix_valid <= 0;
			@(posedge clk);
		end
		pix_valid <= 1;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (pix_stall);
	endtask

	function automatic logic [FIELD_W-1:0] pick_component();
		case ($urandom_range(9))
			0: return 13'd0;
			1: return 13'd4096;
			2: return 13'h1fff;
			3: return FIELD_W'($urandom_range(8191));
			default: return FIELD_W'($urandom_range(4096));
		endcase
	endfunction

	initial begin
		logic [FIELD_W-1:0] r;
		logic [FIELD_W-1:0] g;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_pixel(0, 0, 0);
		send_pixel(4096, 4096, 4096);
		send_pixel(8191, 8191, 8191);
		send_pixel(1, 1, 1);
		send_pixel(4096, 0, 0);
		send_pixel(0, 4096, 4096);
		send_pixel(100, 7, 7);
		send_pixel(0, 4096, 0);
		send_pixel(0, 0, 4096);
		send_pixel(4096, 4096, 0);
		send_pixel(4096, 0, 4096);
		send_pixel(0, 4096, 4095);
		send_pixel(8191, 0, 8191);
		send_pixel(4096, 1, 0);
		send_pixel(4096, 0, 1);
		send_pixel(8191, 8191, 0);
		send_pixel(13'h0aaa, 13'h1555, 13'h0fff);
		send_pixel(13'h1555, 13'h0aaa, 13'h1000);
		for (int n = 0; n < 1850; n++) begin
			calm = (n >= 600 && n < 900);
			r = pick_component();
			g = pick_component();
			if ($urandom_range(9) == 0)
				send_pixel(r, g, g);
			else if ($urandom_range(19) == 0)
				send_pixel(r, r, r);
			else
				send_pixel(r, g, pick_component());
		end
		pix_valid <= 0;
		stimulus_done = 1;
	end

	initial begin
		int cyc;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc == 400) begin
				hsi_stall <= 1;
				repeat (80) @(posedge clk);
			end
			if (calm)
				hsi_stall <= 0;
			else
				hsi_stall <= ($urandom_range(99) < 31);
		end
	end

	initial begin
		wait (stimulus_done);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("Some tests failed");
		$finish;
	end
endmodule

// ----- rgb_to_hsi_convert_core.f -----
src/rthc_pkg.sv
src/rthc_front.sv
src/rthc_cell.sv
src/rgb_to_hsi_convert_core.sv
sim/tb.sv
